[rtl/csseg_pkg.sv]
// Shared types and constants for the CAN command segmenter.
`default_nettype none
package csseg_pkg;

  localparam int CHUNK_DEF   = 7;
  localparam int FRAME_PAYS  = 7;
  localparam logic [8:0] POS_ADDR    = 9'd0;
  localparam logic [8:0] POS_CODE    = 9'd1;
  localparam logic [8:0] POS_MAX     = 9'd255;
  localparam logic [8:0] POS_DISCARD = 9'd256;

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       last_byte;
  } cmd_t;

  typedef struct packed {
    logic [15:0] frame_id;
    logic [7:0]  code_byte;
    logic [7:0]  pay1;
    logic [7:0]  pay2;
    logic [7:0]  pay3;
    logic [7:0]  pay4;
    logic [7:0]  pay5;
    logic [7:0]  pay6;
    logic [7:0]  pay7;
    logic [3:0]  frame_len;
    logic        last_frame;
    logic        error;
  } frame_t;

  typedef struct packed {
    logic shift_en;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/cs_stream_if.sv]
// Valid/ready stream interface carrying one payload word.
`default_nettype none
interface cs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/cs_cell.sv]
// One payload byte cell of the chunk chain.
`default_nettype none
module cs_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  csseg_pkg::cell_ctl_t ctl,
  input  logic [7:0]           din,
  input  logic                 prev_valid,
  output logic                 valid,
  output logic                 take,
  output logic [7:0]           data
);

  logic       valid_q;
  logic [7:0] data_q;

  assign take  = ctl.shift_en && prev_valid && !valid_q;
  assign valid = valid_q;
  assign data  = data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctl.clear) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end
    if (take) begin
      data_q <= din;
    end
  end

endmodule
`default_nettype wire

[rtl/can_command_segmenter.sv]
// Top level: splits byte-wise commands into extended CAN frames.
//
//  port   | dir | word                     | handshake
//  cmd    | in  | cmd_byte, last_byte      | valid/ready
//  frame  | out | id, code, pay1..7, flags | valid/ready
//
// One command byte per cycle; a frame or error word leaves the cycle after
// the byte that closes it. The frame goes to an output register, so a new
// byte is taken whenever that register is empty or being drained.
// A stalled output holds cmd.ready low. Reset clears position, packet count
// and the cell valid bits; no clearing pass.
`default_nettype none
module can_command_segmenter #(
  parameter int CHUNK_BYTES = csseg_pkg::CHUNK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cs_stream_if.sink   cmd,
  cs_stream_if.source frame
);

  logic [8:0]            pos;
  logic [8:0]            pos_next;
  logic [7:0]            pkt;
  logic [7:0]            pkt_next;
  logic [7:0]            addr_hold;
  logic [7:0]            code_hold;
  logic                  out_valid;
  csseg_pkg::frame_t     out_word;
  csseg_pkg::frame_t     res;
  logic                  emit;
  csseg_pkg::cell_ctl_t  ctl;
  logic                  accept;
  logic [7:0]            b;
  logic                  lst;
  logic                  discard;
  logic                  at_max;
  logic                  at_addr;
  logic                  at_code;
  logic                  in_pay;
  logic [CHUNK_BYTES-1:0] cell_valid;
  logic [CHUNK_BYTES-1:0] cell_take;
  logic [CHUNK_BYTES-1:0] chain;
  logic [7:0]             cell_data [CHUNK_BYTES];
  logic [7:0]             pay [csseg_pkg::FRAME_PAYS];
  logic                   full;
  logic [3:0]             len;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !out_valid || frame.ready;
  assign b         = cmd.payload.cmd_byte;
  assign lst       = cmd.payload.last_byte;
  assign discard   = pos[8];
  assign at_max    = (pos == csseg_pkg::POS_MAX);
  assign at_addr   = (pos == csseg_pkg::POS_ADDR);
  assign at_code   = (pos == csseg_pkg::POS_CODE);
  assign in_pay    = !discard && !at_max && !at_addr && !at_code;

  assign chain[0] = 1'b1;

  for (genvar i = 0; i < CHUNK_BYTES; i++) begin : g_cell
    cs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .din        (b),
      .prev_valid (chain[i]),
      .valid      (cell_valid[i]),
      .take       (cell_take[i]),
      .data       (cell_data[i])
    );
    if (i > 0) begin : g_link
      assign chain[i] = cell_valid[i-1];
    end
  end

  assign full = cell_take[CHUNK_BYTES-1];
  assign len  = 4'($countones(cell_valid | cell_take)) + 4'd1;

  always_comb begin
    for (int j = 0; j < csseg_pkg::FRAME_PAYS; j++) begin
      pay[j] = 8'd0;
    end
    for (int j = 0; j < CHUNK_BYTES; j++) begin
      if (cell_valid[j]) begin
        pay[j] = cell_data[j];
      end else if (cell_take[j]) begin
        pay[j] = b;
      end
    end
  end

  always_comb begin
    pos_next     = pos;
    pkt_next     = pkt;
    emit         = 1'b0;
    ctl.shift_en = accept && in_pay;
    ctl.clear    = 1'b0;
    res          = '0;
    res.frame_id  = {addr_hold, pkt};
    res.code_byte = code_hold;
    res.pay1      = pay[0];
    res.pay2      = pay[1];
    res.pay3      = pay[2];
    res.pay4      = pay[3];
    res.pay5      = pay[4];
    res.pay6      = pay[5];
    res.pay7      = pay[6];
    res.frame_len  = len;
    res.last_frame = lst;
    if (accept) begin
      if (discard) begin
        if (lst) begin
          pos_next = csseg_pkg::POS_ADDR;
        end
      end else if (at_max) begin
        emit      = 1'b1;
        res       = '0;
        res.error = 1'b1;
        ctl.clear = 1'b1;
        pkt_next  = 8'd0;
        pos_next  = lst ? csseg_pkg::POS_ADDR : csseg_pkg::POS_DISCARD;
      end else if (at_addr) begin
        pkt_next = 8'd0;
        if (lst) begin
          emit      = 1'b1;
          res       = '0;
          res.error = 1'b1;
        end else begin
          pos_next = csseg_pkg::POS_CODE;
        end
      end else if (at_code) begin
        if (lst) begin
          emit          = 1'b1;
          res.code_byte = b;
          pos_next      = csseg_pkg::POS_ADDR;
          pkt_next      = 8'd0;
        end else begin
          pos_next = pos + 9'd1;
        end
      end else begin
        pos_next = pos + 9'd1;
        if (lst || full) begin
          emit      = 1'b1;
          ctl.clear = 1'b1;
          pkt_next  = lst ? 8'd0 : pkt + 8'd1;
          if (lst) begin
            pos_next = csseg_pkg::POS_ADDR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= csseg_pkg::POS_ADDR;
      pkt       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      pos <= pos_next;
      pkt <= pkt_next;
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept && !discard && at_addr) begin
      addr_hold <= b;
    end
    if (accept && !discard && at_code) begin
      code_hold <= b;
    end
    if (accept && emit) begin
      out_word <= res;
    end
  end

  assign frame.valid   = out_valid;
  assign frame.payload = out_word;

endmodule
`default_nettype wire
